@@ hw/rtl/itoc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itoc_pkg
// shared types, constants and curve tables of the overcurrent trip core
// ----------------------------------------------------------------------------
package itoc_pkg;

	localparam int TIME_BITS_DEF  = 48;
	localparam int FIFO_DEPTH_DEF = 2;
	localparam int CUR_W          = 16;
	localparam int CFG_W          = 27;
	localparam int LOG_FRAC       = 20;
	localparam logic [3:0]  CURVE_DT   = 4'd10;
	localparam logic [63:0] FULL_SCALE = 64'h0000_0000_8000_0000;
	localparam logic [63:0] SAT_MAX    = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [29:0] LN2_Q30    = 30'd744261118;
	localparam logic [5:0]  E_DIV      = 6'd50;
	localparam logic [5:0]  TERM_FIRST = 6'd2;
	localparam logic [5:0]  TERM_LAST  = 6'd12;

	typedef enum logic [2:0] {
		REG_CURVE   = 3'd0,
		REG_PICKUP  = 3'd1,
		REG_DIAL    = 3'd2,
		REG_ADDER   = 3'd3,
		REG_EMRESET = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		EXP_P002 = 2'd0,
		EXP_ONE  = 2'd1,
		EXP_TWO  = 2'd2
	} exp_t;

	typedef enum logic [1:0] {
		K_CLEAR = 2'd0,
		K_RISE  = 2'd1,
		K_FALL  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [3:0]  curve;
		logic [15:0] pickup;
		logic [15:0] dial;
		logic [26:0] adder;
		logic        em;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic        frac;
		logic [15:0] cur;
		logic [15:0] pick;
		logic [31:0] num;
		logic [31:0] den;
		logic [26:0] coef;
	} item_t;

	function automatic logic [26:0] curve_a(input logic [3:0] idx);
		logic [26:0] v;
		case (idx)
			4'd0:    v = 27'd140000;
			4'd1:    v = 27'd13500000;
			4'd2:    v = 27'd80000000;
			4'd3:    v = 27'd120000000;
			4'd4:    v = 27'd51500;
			4'd5:    v = 27'd10400;
			4'd6:    v = 27'd5950000;
			4'd7:    v = 27'd3880000;
			4'd8:    v = 27'd5670000;
			4'd9:    v = 27'd3420;
			default: v = 27'd0;
		endcase
		return v;
	endfunction

	function automatic logic [26:0] curve_b(input logic [3:0] idx);
		logic [26:0] v;
		case (idx)
			4'd0:    v = 27'd13500000;
			4'd1:    v = 27'd47300000;
			4'd2:    v = 27'd80000000;
			4'd3:    v = 27'd120000000;
			4'd4:    v = 27'd4850000;
			4'd5:    v = 27'd2261000;
			4'd6:    v = 27'd18000000;
			4'd7:    v = 27'd21600000;
			4'd8:    v = 27'd29100000;
			4'd9:    v = 27'd323000;
			default: v = 27'd0;
		endcase
		return v;
	endfunction

	function automatic exp_t curve_p(input logic [3:0] idx);
		exp_t v;
		case (idx)
			4'd0, 4'd4, 4'd5, 4'd9:                v = EXP_P002;
			4'd1, 4'd2, 4'd3, 4'd6, 4'd7, 4'd8:    v = EXP_TWO;
			default:                               v = EXP_ONE;
		endcase
		return v;
	endfunction

	function automatic exp_t curve_q(input logic [3:0] idx);
		return (idx < CURVE_DT) ? EXP_TWO : EXP_ONE;
	endfunction

	// floor(2^32 / k) for the small constant divisors
	function automatic logic [31:0] recip(input logic [5:0] k);
		logic [31:0] v;
		case (k)
			6'd2:    v = 32'd2147483648;
			6'd3:    v = 32'd1431655765;
			6'd4:    v = 32'd1073741824;
			6'd5:    v = 32'd858993459;
			6'd6:    v = 32'd715827882;
			6'd7:    v = 32'd613566756;
			6'd8:    v = 32'd536870912;
			6'd9:    v = 32'd477218588;
			6'd10:   v = 32'd429496729;
			6'd11:   v = 32'd390451572;
			6'd12:   v = 32'd357913941;
			6'd50:   v = 32'd85899345;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/inverse_time_overcurrent_trip_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// inverse_time_overcurrent_trip_core
// inverse-time overcurrent trip element with optional gradual reset below pickup
// ----------------------------------------------------------------------------
// Each input word carries one current magnitude and its microsecond timestamp;
// each one gives exactly one output word with the trip flag and the progress
// toward trip (Q1.16, 65536 = full). A front stage takes the elapsed time and
// classifies the sample against pickup in the cycle it is accepted, and pushes
// it into a short queue; a sequencer behind it works out the trip or reset
// time and updates the progress. Work per word is set by the shared
// multiply-divide unit (four partial products plus up to 128 restoring divide
// steps per use): a word below pickup with reset off does not use it, a
// power-law curve or a reset step uses it twice, and the fractional-exponent
// curves first add a logarithm to 20 fraction bits, a divide by 50 and an
// exponential series up to the twelfth power. Configuration writes are taken at once
// and must only be made while the core is idle.
// ----------------------------------------------------------------------------
module inverse_time_overcurrent_trip_core #(
	parameter int TIME_BITS  = itoc_pkg::TIME_BITS_DEF,
	parameter int FIFO_DEPTH = itoc_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// configuration write port
	input  wire logic                                  cfg_we,
	input  wire logic [2:0]                            cfg_index,
	input  wire logic [itoc_pkg::CFG_W-1:0]            cfg_data,
	// sample stream
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// from bit 0: current[15:0], now_us[TIME_BITS-1:0], zero fill
	input  wire logic [((16+TIME_BITS+7)/8)*8-1:0]     s_tdata,
	// result stream
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// from bit 0: trip, progress_level[16:0], zero fill
	output logic [23:0]                                m_tdata
);

	localparam int ITEM_W = $bits(itoc_pkg::item_t);
	localparam int Q_W    = ITEM_W + TIME_BITS;

	// configuration registers
	itoc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.curve  <= itoc_pkg::CURVE_DT;
			cfg_q.pickup <= 16'hFFFF;
			cfg_q.dial   <= 16'd256;
			cfg_q.adder  <= '0;
			cfg_q.em     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				itoc_pkg::REG_CURVE:   cfg_q.curve  <= cfg_data[3:0];
				itoc_pkg::REG_PICKUP:  cfg_q.pickup <= cfg_data[15:0];
				itoc_pkg::REG_DIAL:    cfg_q.dial   <= cfg_data[15:0];
				itoc_pkg::REG_ADDER:   cfg_q.adder  <= cfg_data;
				itoc_pkg::REG_EMRESET: cfg_q.em     <= cfg_data[0];
				default: ; // indexes past the register list are ignored
			endcase
		end
	end

	// front: classify and queue
	logic                 q_full, q_push, q_pop, q_valid;
	itoc_pkg::item_t      f_item, b_item;
	logic [TIME_BITS-1:0] f_elapsed, b_elapsed;
	logic [Q_W-1:0]       q_out;
	logic [TIME_BITS-1:0] now_field;

	assign now_field = s_tdata[16 +: TIME_BITS];

	itoc_front #(.TIME_BITS(TIME_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.cur      (s_tdata[15:0]),
		.now      (now_field),
		.q_full   (q_full),
		.push     (q_push),
		.item     (f_item),
		.elapsed  (f_elapsed)
	);

	itoc_fifo #(.WIDTH(Q_W), .DEPTH(FIFO_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({f_elapsed, f_item}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_data  (q_out)
	);

	assign b_item    = itoc_pkg::item_t'(q_out[ITEM_W-1:0]);
	assign b_elapsed = q_out[Q_W-1:ITEM_W];

	// back: timing sequencer, holds progress and the output register
	logic        r_trip;
	logic [16:0] r_level;

	itoc_back #(.TIME_BITS(TIME_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.pop_valid   (q_valid),
		.pop_item    (b_item),
		.pop_elapsed (b_elapsed),
		.pop         (q_pop),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.out_trip    (r_trip),
		.out_level   (r_level)
	);

	assign m_tdata = {6'd0, r_level, r_trip};

endmodule
`default_nettype wire

@@ hw/rtl/itoc_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itoc_fifo
// short word queue between the classifier and the timing sequencer
// ----------------------------------------------------------------------------
module itoc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  pop_valid,
	output logic [WIDTH-1:0]      pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full      = (cnt_q == CNT_FULL);
	assign pop_valid = (cnt_q != '0);
	assign pop_data  = mem_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/itoc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itoc_front
// accepts samples, takes the elapsed time and classifies against pickup
// ----------------------------------------------------------------------------
module itoc_front #(
	parameter int TIME_BITS = itoc_pkg::TIME_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire itoc_pkg::cfg_t       cfg,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [15:0]          cur,
	input  wire logic [TIME_BITS-1:0] now,
	input  wire logic                 q_full,
	output logic                      push,
	output itoc_pkg::item_t           item,
	output logic [TIME_BITS-1:0]      elapsed
);

	logic [TIME_BITS-1:0] last_time_q;
	logic [15:0]          pick;
	logic [3:0]           row;
	logic                 rise, fall;
	logic [31:0]          pp, cc;
	itoc_pkg::exp_t       ecode;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;
	assign elapsed  = now - last_time_q;

	assign pick = (cfg.pickup == 16'd0) ? 16'd1 : cfg.pickup;
	assign row  = (cfg.curve > itoc_pkg::CURVE_DT) ? itoc_pkg::CURVE_DT : cfg.curve;
	assign rise = cur > pick;
	assign fall = (cur < pick) && cfg.em;
	assign pp   = pick * pick;
	assign cc   = cur * cur;
	assign ecode = rise ? itoc_pkg::curve_p(row) : itoc_pkg::curve_q(row);

	always_comb begin
		item.kind = rise ? itoc_pkg::K_RISE : (fall ? itoc_pkg::K_FALL : itoc_pkg::K_CLEAR);
		item.frac = rise && (ecode == itoc_pkg::EXP_P002);
		item.cur  = cur;
		item.pick = pick;
		item.coef = rise ? itoc_pkg::curve_a(row) : itoc_pkg::curve_b(row);
		unique case (ecode)
			itoc_pkg::EXP_TWO: begin
				item.num = pp;
				item.den = rise ? (cc - pp) : (pp - cc);
			end
			itoc_pkg::EXP_ONE: begin
				item.num = {16'd0, pick};
				item.den = {16'd0, rise ? (cur - pick) : (pick - cur)};
			end
			default: begin
				// fractional exponent, denominator worked out later
				item.num = 32'h0010_0000;
				item.den = 32'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
		end else if (push) begin
			last_time_q <= now;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/itoc_muldiv.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itoc_muldiv
// floor(a*b/d) saturated at cap: four partial products, then up to 128 divide steps
// ----------------------------------------------------------------------------
module itoc_muldiv (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	input  wire logic [63:0] d,
	input  wire logic [63:0] cap,
	output logic             done,
	output logic [63:0]      quo
);

	typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_CHK, MD_DIV} md_state_t;

	md_state_t    state_q;
	logic [63:0]  a_q, b_q, d_q, cap_q, rem_q, qacc_q, quo_q;
	logic [127:0] acc_q;
	logic [1:0]   part_q;
	logic [6:0]   cnt_q;
	logic         done_q;

	logic [31:0]  a_part, b_part;
	logic [63:0]  pp;
	logic [1:0]   sh;
	logic [127:0] pp_ext;
	logic         top, ge;
	logic [63:0]  rs, rnext, qn;
	logic         finish;

	assign a_part = part_q[1] ? a_q[63:32] : a_q[31:0];
	assign b_part = part_q[0] ? b_q[63:32] : b_q[31:0];
	assign pp     = a_part * b_part;
	assign sh     = {1'b0, part_q[1]} + {1'b0, part_q[0]};
	assign pp_ext = {64'd0, pp} << {sh, 5'd0};

	assign top   = rem_q[63];
	assign rs    = {rem_q[62:0], acc_q[127]};
	assign ge    = top || (rs >= d_q);
	assign rnext = ge ? (rs - d_q) : rs;
	assign qn    = {qacc_q[62:0], ge};

	// the result is settled at this edge
	assign finish = ((state_q == MD_CHK) && ((acc_q == '0) || (d_q == '0))) ||
		((state_q == MD_DIV) && (qacc_q[63] || (cnt_q == 7'd0)));

	assign done = done_q;
	assign quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			done_q  <= 1'b0;
			part_q  <= '0;
			cnt_q   <= '0;
			a_q     <= '0;
			b_q     <= '0;
			d_q     <= '0;
			cap_q   <= '0;
			acc_q   <= '0;
			rem_q   <= '0;
			qacc_q  <= '0;
			quo_q   <= '0;
		end else begin
			done_q <= finish;
			unique case (state_q)
				MD_IDLE: begin
					if (start) begin
						a_q     <= a;
						b_q     <= b;
						d_q     <= d;
						cap_q   <= cap;
						acc_q   <= '0;
						part_q  <= '0;
						state_q <= MD_MUL;
					end
				end
				MD_MUL: begin
					acc_q  <= acc_q + pp_ext;
					part_q <= part_q + 2'd1;
					if (part_q == 2'd3) begin
						state_q <= MD_CHK;
					end
				end
				MD_CHK: begin
					if (acc_q == '0) begin
						quo_q   <= '0;
						state_q <= MD_IDLE;
					end else if (d_q == '0) begin
						quo_q   <= cap_q;
						state_q <= MD_IDLE;
					end else begin
						rem_q   <= '0;
						qacc_q  <= '0;
						cnt_q   <= 7'd127;
						state_q <= MD_DIV;
					end
				end
				MD_DIV: begin
					if (qacc_q[63]) begin
						// quotient overflowing 64 bits
						quo_q   <= cap_q;
						state_q <= MD_IDLE;
					end else begin
						rem_q  <= rnext;
						qacc_q <= qn;
						acc_q  <= {acc_q[126:0], 1'b0};
						cnt_q  <= cnt_q - 7'd1;
						if (cnt_q == 7'd0) begin
							quo_q   <= (qn > cap_q) ? cap_q : qn;
							state_q <= MD_IDLE;
						end
					end
				end
				default: state_q <= MD_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/itoc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itoc_back
// timing sequencer: fractional power, trip or reset time, progress update
// ----------------------------------------------------------------------------
module itoc_back #(
	parameter int TIME_BITS = itoc_pkg::TIME_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire itoc_pkg::cfg_t       cfg,
	input  wire logic                 pop_valid,
	input  wire itoc_pkg::item_t      pop_item,
	input  wire logic [TIME_BITS-1:0] pop_elapsed,
	output logic                      pop,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output logic                      out_trip,
	output logic [16:0]               out_level
);

	typedef enum logic [3:0] {
		B_IDLE, B_LOG, B_LDIFF, B_EEST, B_EFIX, B_EXPX, B_TMUL, B_TEST, B_TFIX,
		B_DIALX, B_T1W, B_ADD, B_T2, B_T2W, B_DONE
	} b_state_t;

	b_state_t             state_q;
	itoc_pkg::kind_t      kind_q;
	logic [31:0]          num_q, den_q;
	logic [26:0]          coef_q;
	logic [TIME_BITS-1:0] elapsed_q;
	logic [30:0]          zc_q, zp_q;
	logic [3:0]           nc_q, np_q;
	logic [19:0]          fc_q, fp_q;
	logic [4:0]           lcnt_q;
	logic [31:0]          sd_v_q, sd_qe_q, e_q, x_q, term_q;
	logic [5:0]           sd_k_q, k_q;
	logic [33:0]          sum_q;
	logic [63:0]          t_q, md_a_q, md_b_q, md_d_q, md_cap_q;
	logic                 md_start_q;
	logic [31:0]          inc_q, prog_q;
	logic                 out_valid_q, out_trip_q;
	logic [16:0]          out_level_q;

	logic                 md_done;
	logic [63:0]          md_quo;

	// log2 helpers
	function automatic logic [3:0] lead(input logic [15:0] v);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 1; i < 16; i++) begin
			if (v[i]) n = 4'(i);
		end
		return n;
	endfunction

	logic [61:0] sqc_full, sqp_full;
	logic [31:0] sqc, sqp;
	logic [23:0] lc, lp, ldiff;
	logic [63:0] sd_prod, tm_prod;
	logic [37:0] sd_back;
	logic [31:0] sd_rem, sd_q;
	logic [61:0] x_prod;
	logic [31:0] x_val;
	logic [33:0] sum_next;
	logic [42:0] dial_x;
	logic [64:0] t_add;
	logic [32:0] prog_sum;
	logic [31:0] prog_next;
	logic        out_load;

	assign sqc_full = zc_q * zc_q;
	assign sqp_full = zp_q * zp_q;
	assign sqc      = sqc_full[61:30];
	assign sqp      = sqp_full[61:30];
	assign lc       = {nc_q, fc_q};
	assign lp       = {np_q, fp_q};
	assign ldiff    = (lc > lp) ? (lc - lp) : 24'd0;

	// small constant division: reciprocal estimate, one correction
	assign sd_prod  = sd_v_q * itoc_pkg::recip(sd_k_q);
	assign sd_back  = sd_qe_q * sd_k_q;
	assign sd_rem   = sd_v_q - sd_back[31:0];
	assign sd_q     = (sd_rem >= {26'd0, sd_k_q}) ? (sd_qe_q + 32'd1) : sd_qe_q;

	assign x_prod   = e_q * itoc_pkg::LN2_Q30;
	assign x_val    = x_prod[51:20];
	assign tm_prod  = term_q * x_q;
	assign sum_next = sum_q + {2'd0, sd_q};
	assign dial_x   = cfg.dial * coef_q;
	assign t_add    = {1'b0, t_q} + {38'd0, cfg.adder};

	assign prog_sum = {1'b0, prog_q} + {1'b0, inc_q};

	always_comb begin
		unique case (kind_q)
			itoc_pkg::K_RISE:
				prog_next = (prog_sum > itoc_pkg::FULL_SCALE[32:0]) ?
					itoc_pkg::FULL_SCALE[31:0] : prog_sum[31:0];
			itoc_pkg::K_FALL:
				prog_next = (inc_q >= prog_q) ? 32'd0 : (prog_q - inc_q);
			default:
				prog_next = 32'd0;
		endcase
	end

	assign pop       = (state_q == B_IDLE) && pop_valid;
	assign out_load  = (state_q == B_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_trip  = out_trip_q;
	assign out_level = out_level_q;

	itoc_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start_q),
		.a      (md_a_q),
		.b      (md_b_q),
		.d      (md_d_q),
		.cap    (md_cap_q),
		.done   (md_done),
		.quo    (md_quo)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q    <= pop_item.kind;
			num_q     <= pop_item.num;
			coef_q    <= pop_item.coef;
			elapsed_q <= pop_elapsed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			md_start_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_trip_q  <= 1'b0;
			out_level_q <= '0;
			prog_q      <= '0;
			den_q       <= '0;
			zc_q        <= '0;
			zp_q        <= '0;
			nc_q        <= '0;
			np_q        <= '0;
			fc_q        <= '0;
			fp_q        <= '0;
			lcnt_q      <= '0;
			sd_v_q      <= '0;
			sd_k_q      <= '0;
			sd_qe_q     <= '0;
			e_q         <= '0;
			x_q         <= '0;
			term_q      <= '0;
			sum_q       <= '0;
			k_q         <= '0;
			t_q         <= '0;
			inc_q       <= '0;
			md_a_q      <= '0;
			md_b_q      <= '0;
			md_d_q      <= '0;
			md_cap_q    <= '0;
		end else begin
			// one-cycle start pulse as the operands are loaded
			md_start_q <= (state_q == B_DIALX) || (state_q == B_T2);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						den_q  <= pop_item.den;
						nc_q   <= lead(pop_item.cur);
						np_q   <= lead(pop_item.pick);
						zc_q   <= 31'(pop_item.cur) << (5'd30 - {1'b0, lead(pop_item.cur)});
						zp_q   <= 31'(pop_item.pick) << (5'd30 - {1'b0, lead(pop_item.pick)});
						fc_q   <= '0;
						fp_q   <= '0;
						lcnt_q <= '0;
						if (pop_item.kind == itoc_pkg::K_CLEAR) begin
							state_q <= B_DONE;
						end else if (pop_item.frac) begin
							state_q <= B_LOG;
						end else begin
							state_q <= B_DIALX;
						end
					end
				end
				B_LOG: begin
					// one fraction bit of both logarithms per cycle
					fc_q   <= {fc_q[18:0], sqc[31]};
					fp_q   <= {fp_q[18:0], sqp[31]};
					zc_q   <= sqc[31] ? sqc[31:1] : sqc[30:0];
					zp_q   <= sqp[31] ? sqp[31:1] : sqp[30:0];
					lcnt_q <= lcnt_q + 5'd1;
					if (lcnt_q == 5'(itoc_pkg::LOG_FRAC - 1)) begin
						state_q <= B_LDIFF;
					end
				end
				B_LDIFF: begin
					sd_v_q  <= {8'd0, ldiff};
					sd_k_q  <= itoc_pkg::E_DIV;
					state_q <= B_EEST;
				end
				B_EEST: begin
					sd_qe_q <= sd_prod[63:32];
					state_q <= B_EFIX;
				end
				B_EFIX: begin
					e_q     <= sd_q;
					state_q <= B_EXPX;
				end
				B_EXPX: begin
					x_q     <= x_val;
					term_q  <= x_val;
					sum_q   <= {2'd0, x_val};
					k_q     <= itoc_pkg::TERM_FIRST;
					state_q <= B_TMUL;
				end
				B_TMUL: begin
					sd_v_q  <= tm_prod[61:30];
					sd_k_q  <= k_q;
					state_q <= B_TEST;
				end
				B_TEST: begin
					sd_qe_q <= sd_prod[63:32];
					state_q <= B_TFIX;
				end
				B_TFIX: begin
					term_q <= sd_q;
					sum_q  <= sum_next;
					if (k_q == itoc_pkg::TERM_LAST) begin
						den_q   <= 32'(sum_next >> 10);
						state_q <= B_DIALX;
					end else begin
						k_q     <= k_q + 6'd1;
						state_q <= B_TMUL;
					end
				end
				B_DIALX: begin
					md_a_q     <= {21'd0, dial_x};
					md_b_q     <= {32'd0, num_q};
					md_d_q     <= {24'd0, den_q, 8'd0};
					md_cap_q   <= itoc_pkg::SAT_MAX;
					state_q    <= B_T1W;
				end
				B_T1W: begin
					if (md_done) begin
						t_q     <= md_quo;
						state_q <= (kind_q == itoc_pkg::K_RISE) ? B_ADD : B_T2;
					end
				end
				B_ADD: begin
					t_q     <= t_add[64] ? itoc_pkg::SAT_MAX : t_add[63:0];
					state_q <= B_T2;
				end
				B_T2: begin
					md_a_q     <= 64'(elapsed_q);
					md_b_q     <= itoc_pkg::FULL_SCALE;
					md_d_q     <= t_q;
					md_cap_q   <= itoc_pkg::FULL_SCALE;
					state_q    <= B_T2W;
				end
				B_T2W: begin
					if (md_done) begin
						inc_q   <= md_quo[31:0];
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (out_load) begin
						prog_q      <= prog_next;
						out_trip_q  <= (prog_next == itoc_pkg::FULL_SCALE[31:0]);
						out_level_q <= prog_next[31:15];
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
